// File: sv/rba_pkg.sv
// Shared constants and types of the reference-counted block allocator.
package rba_pkg;

  // Fixed payload widths.
  localparam int MODE_W   = 2;
  localparam int ID_W     = 10;
  localparam int STATUS_W = 3;
  localparam int REF_W    = 16;
  localparam int LEVEL_W  = 11;

  // Parameter defaults.
  localparam int NUM_BLOCKS_DEF = 256;
  localparam int COUNT_BITS_DEF = 16;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_REF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_UNKNOWN   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_HELD  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_SATURATED = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } rba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } rba_sts_t;

endpackage

// File: sv/rba_if.sv
// Handshake interfaces for the allocator request and result channels.
interface rba_in_if;
  logic                       valid;
  logic                       ready;
  logic [rba_pkg::MODE_W-1:0] mode;
  logic [rba_pkg::ID_W-1:0]   block_id;

  modport source (output valid, output mode, output block_id, input ready);
  modport sink (input valid, input mode, input block_id, output ready);
endinterface

interface rba_out_if;
  logic                         valid;
  logic                         ready;
  logic [rba_pkg::STATUS_W-1:0] status;
  logic [rba_pkg::ID_W-1:0]     granted_block;
  logic [rba_pkg::REF_W-1:0]    ref_count;
  logic                         exclusive;
  logic [rba_pkg::LEVEL_W-1:0]  free_count;
  logic [rba_pkg::LEVEL_W-1:0]  used_count;

  modport source (output valid, output status, output granted_block, output ref_count,
                  output exclusive, output free_count, output used_count, input ready);
  modport sink (input valid, input status, input granted_block, input ref_count,
                input exclusive, input free_count, input used_count, output ready);
endinterface

// File: sv/rba_ctrl.sv
// Sequencing state machine of the block allocator.
module rba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rba_pkg::rba_sts_t sts_i,
  output rba_pkg::rba_cmd_t cmd_o
);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The item completes only once the result register can take it.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/rba_dp.sv
// Datapath of the block allocator: free stack, count memory and result register.
module rba_dp #(
  parameter int NUM_BLOCKS = rba_pkg::NUM_BLOCKS_DEF,
  parameter int COUNT_BITS = rba_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rba_pkg::rba_cmd_t            cmd_i,
  output rba_pkg::rba_sts_t            sts_o,
  input  logic [rba_pkg::MODE_W-1:0]   mode_i,
  input  logic [rba_pkg::ID_W-1:0]     block_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rba_pkg::STATUS_W-1:0] status_o,
  output logic [rba_pkg::ID_W-1:0]     granted_block_o,
  output logic [rba_pkg::REF_W-1:0]    ref_count_o,
  output logic                         exclusive_o,
  output logic [rba_pkg::LEVEL_W-1:0]  free_count_o,
  output logic [rba_pkg::LEVEL_W-1:0]  used_count_o
);

  localparam int IdxW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int DepthW = $clog2(NUM_BLOCKS + 1);
  localparam int ExtW   = (COUNT_BITS > rba_pkg::REF_W) ? COUNT_BITS : rba_pkg::REF_W;
  localparam logic [DepthW-1:0]           DepthFull = DepthW'(NUM_BLOCKS);
  localparam logic [rba_pkg::LEVEL_W-1:0] NumLevel  = rba_pkg::LEVEL_W'(NUM_BLOCKS);
  localparam logic [IdxW-1:0]             LastIdx   = IdxW'(NUM_BLOCKS - 1);
  localparam logic [COUNT_BITS-1:0]       CountMax  = '1;
  localparam logic [COUNT_BITS-1:0]       CountOne  = COUNT_BITS'(1);

  logic [rba_pkg::ID_W-1:0] stack_mem [NUM_BLOCKS];
  logic [COUNT_BITS-1:0]    count_mem [NUM_BLOCKS];

  logic [IdxW-1:0]             clr_idx_q;
  logic [DepthW-1:0]           depth_q, depth_d;
  logic [rba_pkg::MODE_W-1:0]  mode_q;
  logic [rba_pkg::ID_W-1:0]    id_q;
  logic [rba_pkg::ID_W-1:0]    stack_rd_q;
  logic [COUNT_BITS-1:0]       cnt_rd_q;

  logic                        stack_we;
  logic [IdxW-1:0]             stack_wa;
  logic [rba_pkg::ID_W-1:0]    stack_wd;
  logic                        count_we;
  logic [IdxW-1:0]             count_wa;
  logic [COUNT_BITS-1:0]       count_wd;
  logic [IdxW-1:0]             stack_ra;

  logic [rba_pkg::STATUS_W-1:0] res_status;
  logic [rba_pkg::ID_W-1:0]     res_blk;
  logic [COUNT_BITS-1:0]        res_cnt;
  logic [ExtW-1:0]              res_cnt_ext;
  logic                         unknown;

  logic                         out_valid_q;
  logic [rba_pkg::STATUS_W-1:0] status_q;
  logic [rba_pkg::ID_W-1:0]     blk_q;
  logic [rba_pkg::REF_W-1:0]    ref_q;
  logic                         excl_q;
  logic [rba_pkg::LEVEL_W-1:0]  free_q;
  logic [rba_pkg::LEVEL_W-1:0]  used_q;

  assign stack_ra         = IdxW'(depth_q - DepthW'(1));
  assign unknown          = {1'b0, id_q} >= NumLevel;
  assign sts_o.clear_last = (clr_idx_q == LastIdx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Operation logic, evaluated on the data read in the accept cycle.
  always_comb begin
    res_status = rba_pkg::STS_OK;
    res_blk    = id_q;
    res_cnt    = '0;
    depth_d    = depth_q;
    stack_we   = 1'b0;
    stack_wa   = depth_q[IdxW-1:0];
    stack_wd   = id_q;
    count_we   = 1'b0;
    count_wa   = id_q[IdxW-1:0];
    count_wd   = '0;
    if (mode_q == rba_pkg::MODE_ALLOC) begin
      if (depth_q == '0) begin
        res_status = rba_pkg::STS_EMPTY;
        res_blk    = '0;
      end else begin
        depth_d  = depth_q - DepthW'(1);
        res_blk  = stack_rd_q;
        res_cnt  = CountOne;
        count_we = 1'b1;
        count_wa = stack_rd_q[IdxW-1:0];
        count_wd = CountOne;
      end
    end else if (unknown) begin
      res_status = rba_pkg::STS_UNKNOWN;
    end else begin
      res_cnt = cnt_rd_q;
      case (mode_q)
        rba_pkg::MODE_ADD_REF: begin
          if (cnt_rd_q == '0) begin
            res_status = rba_pkg::STS_NOT_HELD;
          end else if (cnt_rd_q == CountMax) begin
            res_status = rba_pkg::STS_SATURATED;
          end else begin
            res_cnt  = cnt_rd_q + CountOne;
            count_we = 1'b1;
            count_wd = cnt_rd_q + CountOne;
          end
        end
        rba_pkg::MODE_RELEASE: begin
          if (cnt_rd_q == '0) begin
            res_status = rba_pkg::STS_NOT_HELD;
          end else begin
            res_cnt  = cnt_rd_q - CountOne;
            count_we = 1'b1;
            count_wd = cnt_rd_q - CountOne;
            // The last reference returns the block to the top of the stack.
            if ((cnt_rd_q == CountOne) && (depth_q < DepthFull)) begin
              stack_we = 1'b1;
              depth_d  = depth_q + DepthW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_cnt_ext = ExtW'(res_cnt);

  // Free stack memory; the clearing pass loads descending ids.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      stack_mem[clr_idx_q] <= rba_pkg::ID_W'(LastIdx - clr_idx_q);
    end else if (cmd_i.commit && stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    if (cmd_i.accept) begin
      stack_rd_q <= stack_mem[stack_ra];
    end
  end

  // Reference count memory; the clearing pass zeroes every entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      count_mem[clr_idx_q] <= '0;
    end else if (cmd_i.commit && count_we) begin
      count_mem[count_wa] <= count_wd;
    end
    if (cmd_i.accept) begin
      cnt_rd_q <= count_mem[block_id_i[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      id_q   <= block_id_i;
    end
    if (cmd_i.commit) begin
      status_q <= res_status;
      blk_q    <= res_blk;
      ref_q    <= res_cnt_ext[rba_pkg::REF_W-1:0];
      excl_q   <= (res_cnt == CountOne);
      free_q   <= rba_pkg::LEVEL_W'(depth_d);
      used_q   <= NumLevel - rba_pkg::LEVEL_W'(depth_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      depth_q     <= DepthFull;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear && !sts_o.clear_last) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
      end
      if (cmd_i.commit) begin
        depth_q     <= depth_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = blk_q;
  assign ref_count_o     = ref_q;
  assign exclusive_o     = excl_q;
  assign free_count_o    = free_q;
  assign used_count_o    = used_q;

endmodule

// File: sv/refcounted_block_allocator.sv
// Top level of the reference-counted block allocator.
//
// Requests arrive on in_i (mode, block_id) and each yields one result item on
// out_o (status, granted_block, ref_count, exclusive, free_count, used_count).
// Both channels move an item when valid and ready are high at a clock edge.
// An item accepted at one edge has its result loaded into the output register
// by the update step that follows it, and the block takes no new item until
// that update is done: the accept step reads the free stack and the count
// memory, and the update step writes them back and loads the result register.
// Memory reads are registered, so every item needs both steps.
// After reset the block runs a clearing pass over all NUM_BLOCKS entries that fills
// the free stack with descending ids (block 0 on top) and zeroes every count;
// in_i.ready stays low during it.
// When the receiver stalls, the finished result waits in the output register
// while the next item is accepted; that item then waits in its update cycle
// until the output register frees, and in_i.ready stays low meanwhile.
module refcounted_block_allocator #(
  parameter int NUM_BLOCKS = rba_pkg::NUM_BLOCKS_DEF,
  parameter int COUNT_BITS = rba_pkg::COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rba_in_if.sink       in_i,
  rba_out_if.source    out_o
);

  rba_pkg::rba_cmd_t cmd;
  rba_pkg::rba_sts_t sts;

  rba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_i.mode),
    .block_id_i      (in_i.block_id),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .status_o        (out_o.status),
    .granted_block_o (out_o.granted_block),
    .ref_count_o     (out_o.ref_count),
    .exclusive_o     (out_o.exclusive),
    .free_count_o    (out_o.free_count),
    .used_count_o    (out_o.used_count)
  );

endmodule

// File: test/refcounted_block_allocator_tb.sv
// Self-checking testbench for the reference-counted block allocator.
module refcounted_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BLOCKS = rba_pkg::NUM_BLOCKS_DEF;
  localparam int COUNT_BITS = rba_pkg::COUNT_BITS_DEF;
  localparam int MODE_W     = rba_pkg::MODE_W;
  localparam int ID_W       = rba_pkg::ID_W;
  localparam int STATUS_W   = rba_pkg::STATUS_W;
  localparam int REF_W      = rba_pkg::REF_W;
  localparam int LEVEL_W    = rba_pkg::LEVEL_W;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_OPS = 500;
  localparam int MAX_GAP    = 12;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_block;
    logic [REF_W-1:0]    ref_count;
    logic                exclusive;
    logic [LEVEL_W-1:0]  free_count;
    logic [LEVEL_W-1:0]  used_count;
  } alloc_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic              known;
    alloc_result_t     res;
  } step_t;

  // Rows with known set carry a hand-written result; the rest use the predictor.
  localparam step_t DIR_TBL [20] = '{
    '{rba_pkg::MODE_QUERY, 10'd0, 1'b1,
      '{rba_pkg::STS_OK, 10'd0, 16'd0, 1'b0, 11'd256, 11'd0}},
    '{rba_pkg::MODE_ALLOC, 10'd1023, 1'b1,
      '{rba_pkg::STS_OK, 10'd0, 16'd1, 1'b1, 11'd255, 11'd1}},
    '{rba_pkg::MODE_ALLOC, 10'd0, 1'b1,
      '{rba_pkg::STS_OK, 10'd1, 16'd1, 1'b1, 11'd254, 11'd2}},
    '{rba_pkg::MODE_ADD_REF, 10'd0, 1'b0, '0},
    '{rba_pkg::MODE_ADD_REF, 10'd0, 1'b0, '0},
    '{rba_pkg::MODE_QUERY, 10'd0, 1'b0, '0},
    '{rba_pkg::MODE_QUERY, 10'd1023, 1'b1,
      '{rba_pkg::STS_UNKNOWN, 10'd1023, 16'd0, 1'b0, 11'd254, 11'd2}},
    '{rba_pkg::MODE_ADD_REF, 10'd256, 1'b1,
      '{rba_pkg::STS_UNKNOWN, 10'd256, 16'd0, 1'b0, 11'd254, 11'd2}},
    '{rba_pkg::MODE_RELEASE, 10'd512, 1'b1,
      '{rba_pkg::STS_UNKNOWN, 10'd512, 16'd0, 1'b0, 11'd254, 11'd2}},
    '{rba_pkg::MODE_ADD_REF, 10'd255, 1'b1,
      '{rba_pkg::STS_NOT_HELD, 10'd255, 16'd0, 1'b0, 11'd254, 11'd2}},
    '{rba_pkg::MODE_RELEASE, 10'd2, 1'b1,
      '{rba_pkg::STS_NOT_HELD, 10'd2, 16'd0, 1'b0, 11'd254, 11'd2}},
    '{rba_pkg::MODE_QUERY, 10'd255, 1'b1,
      '{rba_pkg::STS_OK, 10'd255, 16'd0, 1'b0, 11'd254, 11'd2}},
    '{rba_pkg::MODE_RELEASE, 10'd0, 1'b0, '0},
    '{rba_pkg::MODE_RELEASE, 10'd0, 1'b0, '0},
    '{rba_pkg::MODE_RELEASE, 10'd0, 1'b0, '0},
    '{rba_pkg::MODE_ALLOC, 10'd682, 1'b0, '0},
    '{rba_pkg::MODE_RELEASE, 10'd1, 1'b0, '0},
    '{rba_pkg::MODE_ADD_REF, 10'd341, 1'b0, '0},
    '{rba_pkg::MODE_QUERY, 10'd1, 1'b0, '0},
    '{rba_pkg::MODE_ALLOC, 10'd0, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rba_in_if  req_if ();
  rba_out_if rsp_if ();

  refcounted_block_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted pool state.
  logic [ID_W-1:0]       pool_stack [NUM_BLOCKS];
  logic [COUNT_BITS-1:0] pool_refs  [NUM_BLOCKS];
  int                    pool_depth;

  alloc_result_t pending_results [$];
  int  mismatches = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_empty = 0;
  int  n_not_held = 0;
  int  idle_cycles = 0;
  bit  quiet_mode = 1'b0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  task automatic reset_pool();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      pool_stack[i] = ID_W'(NUM_BLOCKS - 1 - i);
      pool_refs[i]  = '0;
    end
    pool_depth = NUM_BLOCKS;
  endtask

  function automatic alloc_result_t next_alloc_result(logic [MODE_W-1:0] m,
                                                      logic [ID_W-1:0] id);
    alloc_result_t         r;
    logic [COUNT_BITS-1:0] c;
    r = '0;
    r.status = rba_pkg::STS_OK;
    r.granted_block = id;
    c = '0;
    if (m == rba_pkg::MODE_ALLOC) begin
      if (pool_depth == 0) begin
        r.status = rba_pkg::STS_EMPTY;
        r.granted_block = '0;
      end else begin
        pool_depth--;
        r.granted_block = pool_stack[pool_depth];
        pool_refs[r.granted_block] = COUNT_BITS'(1);
        c = COUNT_BITS'(1);
      end
    end else if (int'(id) >= NUM_BLOCKS) begin
      r.status = rba_pkg::STS_UNKNOWN;
    end else begin
      c = pool_refs[id];
      if (m == rba_pkg::MODE_ADD_REF) begin
        if (c == '0) begin
          r.status = rba_pkg::STS_NOT_HELD;
        end else if (c == {COUNT_BITS{1'b1}}) begin
          r.status = rba_pkg::STS_SATURATED;
        end else begin
          c = c + 1'b1;
          pool_refs[id] = c;
        end
      end else if (m == rba_pkg::MODE_RELEASE) begin
        if (c == '0) begin
          r.status = rba_pkg::STS_NOT_HELD;
        end else begin
          c = c - 1'b1;
          pool_refs[id] = c;
          // A block whose last reference goes away returns to the top of the stack.
          if (c == '0 && pool_depth < NUM_BLOCKS) begin
            pool_stack[pool_depth] = id;
            pool_depth++;
          end
        end
      end
    end
    r.ref_count  = REF_W'(c);
    r.exclusive  = (c == COUNT_BITS'(1));
    r.free_count = LEVEL_W'(pool_depth);
    r.used_count = LEVEL_W'(NUM_BLOCKS - pool_depth);
    return r;
  endfunction

  // Returns some block that is currently held, or -1 when none is.
  function automatic int pick_held();
    int start;
    int idx;
    start = $urandom_range(0, NUM_BLOCKS - 1);
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      idx = (start + k) % NUM_BLOCKS;
      if (pool_refs[idx] != '0) return idx;
    end
    return -1;
  endfunction

  // Entered just after a rising edge; returns at the edge that accepts the item.
  task automatic send_op(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
                         logic known, alloc_result_t fixed_res);
    int            gap;
    alloc_result_t r;
    gap = (quiet_mode || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.block_id <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    r = next_alloc_result(m, id);
    pending_results.insert(pending_results.size(), known ? fixed_res : r);
    n_sent++;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void note_mismatch(string what, alloc_result_t want, alloc_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: want sts=%0d blk=%0d cnt=%0d excl=%0d free=%0d used=%0d",
               $realtime, what, want.status, want.granted_block, want.ref_count,
               want.exclusive, want.free_count, want.used_count);
      $display("[%0t] %s:  got sts=%0d blk=%0d cnt=%0d excl=%0d free=%0d used=%0d",
               $realtime, what, got.status, got.granted_block, got.ref_count,
               got.exclusive, got.free_count, got.used_count);
    end
  endfunction

  // Result side: random stalls, checks each accepted item in order.
  initial begin
    int            stall;
    alloc_result_t got;
    alloc_result_t want;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = (quiet_mode || rx_burst) ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_if.valid !== 1'b1) @(posedge clk_i);
      got = '{rsp_if.status, rsp_if.granted_block, rsp_if.ref_count, rsp_if.exclusive,
              rsp_if.free_count, rsp_if.used_count};
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
      n_checked++;
      if (got.status == rba_pkg::STS_EMPTY) n_empty++;
      if (got.status == rba_pkg::STS_NOT_HELD) n_not_held++;
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  // Ends the run when neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int                hold;
    int                sel;
    int                alloc_weight;
    logic [MODE_W-1:0] m;
    logic [ID_W-1:0]   id;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.mode     <= rba_pkg::MODE_ALLOC;
    req_if.block_id <= '0;
    reset_pool();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TBL[i]) begin
      send_op(DIR_TBL[i].mode, DIR_TBL[i].id, DIR_TBL[i].known, DIR_TBL[i].res);
    end

    // Empty the pool, then keep asking so the no-free-block case shows up.
    while (pool_depth > 0) begin
      send_op(rba_pkg::MODE_ALLOC, ID_W'($urandom_range(0, 1023)), 1'b0, '0);
    end
    repeat (3) send_op(rba_pkg::MODE_ALLOC, ID_W'($urandom_range(0, 1023)), 1'b0, '0);

    // A short run of requests on one block at full rate with no idling.
    wait_results_drained();
    quiet_mode = 1'b1;
    hold = pick_held();
    if (hold >= 0) begin
      repeat (6) send_op(rba_pkg::MODE_ADD_REF, ID_W'(hold), 1'b0, '0);
      send_op(rba_pkg::MODE_QUERY, ID_W'(hold), 1'b0, '0);
      send_op(rba_pkg::MODE_RELEASE, ID_W'(hold), 1'b0, '0);
    end
    quiet_mode = 1'b0;

    // Mostly well-formed traffic on held blocks, with alternating pool pressure.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 200 == 0) alloc_weight = ((i / 200) % 2 == 0) ? 15 : 60;
      sel = $urandom_range(0, 99);
      hold = pick_held();
      id = ID_W'($urandom_range(0, 1023));
      if (sel < alloc_weight || (sel < 90 && hold < 0)) begin
        m = rba_pkg::MODE_ALLOC;
      end else if (sel < 90) begin
        id = ID_W'(hold);
        sel = $urandom_range(0, 9);
        m = (sel < 3) ? rba_pkg::MODE_ADD_REF :
            (sel < 8) ? rba_pkg::MODE_RELEASE : rba_pkg::MODE_QUERY;
      end else begin
        m = MODE_W'($urandom_range(1, 3));
      end
      send_op(m, id, 1'b0, '0);
      if (i == RANDOM_OPS / 2) wait_results_drained();
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    $display("sent %0d requests and checked %0d results", n_sent, n_checked);
    $display("empty-pool answers %0d, not-held answers %0d", n_empty, n_not_held);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
